// File: design/linear_array_deque_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the linear array deque
// Shared property forms that the core uses for its concurrent checks.
// ---------------------------------------------------------------------------
`ifndef LINEAR_ARRAY_DEQUE_CORE_DEFINES_SVH
`define LINEAR_ARRAY_DEQUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define LAD_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define LAD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

// File: design/lad_pkg.sv
// ---------------------------------------------------------------------------
// Linear array deque package
// Beat types, operation and status codes, and the cell control word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lad_pkg;

  localparam int WORD_W = 32;
  localparam int CAP_W  = 7;
  localparam int ADDR_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam logic [0:0] REG_CAPACITY = 1'b0;

  localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
  localparam logic [1:0] MODE_PUSH_REAR  = 2'd1;
  localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
  localparam logic [1:0] MODE_POP_REAR   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam logic [WORD_W-1:0] NONE_WORD = '1;

  // Cell operations: keep, take the left neighbor, take the right
  // neighbor, or take the pushed word if this cell sits just past the end.
  localparam logic [1:0] OP_HOLD      = 2'd0;
  localparam logic [1:0] OP_SHIFT_IN  = 2'd1;
  localparam logic [1:0] OP_SHIFT_OUT = 2'd2;
  localparam logic [1:0] OP_APPEND    = 2'd3;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_out;
    logic [1:0]               status;
  } rsp_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [WORD_W-1:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: design/lad_cell.sv
// ---------------------------------------------------------------------------
// Deque storage cell
// Holds one word and moves it to or from its neighbors on command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lad_cell (
  input  wire logic                      clk,
  input  wire lad_pkg::cell_ctl_t        ctl,
  input  wire logic                      at_count,
  input  wire logic [lad_pkg::WORD_W-1:0] left_word,
  input  wire logic [lad_pkg::WORD_W-1:0] right_word,
  output logic      [lad_pkg::WORD_W-1:0] word
);
  import lad_pkg::*;

  logic [WORD_W-1:0] word_next;

  always_comb begin
    word_next = word;
    case (ctl.op)
      OP_HOLD:      word_next = word;
      OP_SHIFT_IN:  word_next = left_word;
      OP_SHIFT_OUT: word_next = right_word;
      OP_APPEND:    if (at_count) word_next = ctl.value;
      default:      word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

`default_nettype wire

// File: design/lad_chain.sv
// ---------------------------------------------------------------------------
// Deque cell chain
// A row of storage cells whose head (cell zero) is one end of the deque.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lad_chain #(
  parameter int DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire lad_pkg::cell_ctl_t          ctl,
  input  wire logic [$clog2(DEPTH):0]      count,
  output logic      [lad_pkg::WORD_W-1:0]  head
);
  import lad_pkg::*;

  localparam int CNT_W = $clog2(DEPTH) + 1;

  logic [WORD_W-1:0] words [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_word;
    logic [WORD_W-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = ctl.value;
    end else begin : g_inner_l
      assign left_word = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = words[i];
    end else begin : g_inner_r
      assign right_word = words[i+1];
    end

    lad_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .at_count   (count == CNT_W'(i)),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (words[i])
    );
  end

  assign head = words[0];

endmodule

`default_nettype wire

// File: design/linear_array_deque_core.sv
// ---------------------------------------------------------------------------
// Linear array deque core
// Double-ended queue of signed words with linear, non-wrapping indices.
// ---------------------------------------------------------------------------
// Usage: each request beat on req carries a mode (push front, push rear,
// pop front, pop rear) and a word. Every request produces exactly one
// response beat on rsp with the popped word (all ones for pushes and on
// underflow) and a status of ok, overflow or underflow.
// Both channels use valid/stall: a beat moves on a clock edge where valid
// is high and stall is low. A request's response is registered, and the
// block sustains one request per cycle while req_stall is low; the limit
// is the pointer update and cell shift that each operation needs.
// The contents are held twice, in two chains of cells: one keeps the
// front word in its head cell, the other keeps the rear word in its head.
// A push shifts one chain by one cell and appends to the other; a pop
// shifts only the chain whose head it reads, so both ends are fixed cells.
// When the receiver stalls, one finished response waits in the output
// register and one more in a skid register; req_stall rises only once the
// skid register is full. Reset (rst, synchronous) empties the deque and
// sets capacity to 64; no cell contents are cleared and no sweep follows.
// Capacity is written through the APB port at byte address 0.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "linear_array_deque_core_defines.svh"

module linear_array_deque_core #(
  parameter int DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Request channel
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire lad_pkg::req_t               req,
  // Response channel
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output lad_pkg::rsp_t                    rsp,
  // Configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lad_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  import lad_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = AW + 1;
  // Width that holds both the capacity register and the depth.
  localparam int EW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Deque state.
  logic [AW-1:0]    front;
  logic [AW-1:0]    rear;
  logic [CNT_W-1:0] count;
  logic [CAP_W-1:0] capacity;

  logic [AW-1:0]    front_next;
  logic [AW-1:0]    rear_next;
  logic [CNT_W-1:0] count_next;

  // Output register and skid register.
  rsp_t rsp_skid;
  logic skid_valid;

  logic accept;
  logic take;
  logic is_empty;

  logic [EW-1:0] eff_cap;
  logic          rear_full;

  cell_ctl_t     front_ctl;
  cell_ctl_t     rear_ctl;
  logic [WORD_W-1:0] front_head;
  logic [WORD_W-1:0] rear_head;

  rsp_t res;

  // Accepted beats that the assertions look at.
  logic overflow_beat;
  logic last_pop_beat;

  // ----------------------------------------------------------------------
  // Configuration port. Register select uses the word address bit only.
  // ----------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, capacity} : '0;

  // Capacity is clamped to the range one to DEPTH.
  always_comb begin
    if (capacity == '0) begin
      eff_cap = EW'(1);
    end else if (EW'(capacity) > EW'(DEPTH)) begin
      eff_cap = EW'(DEPTH);
    end else begin
      eff_cap = EW'(capacity);
    end
  end

  assign rear_full = EW'(rear) >= (eff_cap - EW'(1));
  assign is_empty  = (count == '0);

  // ----------------------------------------------------------------------
  // Handshake. A request is refused only when the skid register is full.
  // ----------------------------------------------------------------------
  assign req_stall = skid_valid;
  assign accept    = req_valid && !req_stall;
  assign take      = rsp_valid && !rsp_stall;

  // ----------------------------------------------------------------------
  // Operation decode: response, pointer update and chain commands.
  // ----------------------------------------------------------------------
  always_comb begin
    res.data_out    = NONE_WORD;
    res.status      = ST_OK;
    front_next      = front;
    rear_next       = rear;
    count_next      = count;
    front_ctl.op    = OP_HOLD;
    front_ctl.value = req.value;
    rear_ctl.op     = OP_HOLD;
    rear_ctl.value  = req.value;

    case (req.mode)
      MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
        if (is_empty) begin
          // First word lands at index zero; both chains take it at cell 0.
          front_next   = '0;
          rear_next    = '0;
          count_next   = CNT_W'(1);
          front_ctl.op = OP_APPEND;
          rear_ctl.op  = OP_APPEND;
        end else if (req.mode == MODE_PUSH_FRONT) begin
          if (front == '0) begin
            res.status = ST_OVERFLOW;
          end else begin
            front_next   = front - AW'(1);
            count_next   = count + CNT_W'(1);
            front_ctl.op = OP_SHIFT_IN;
            rear_ctl.op  = OP_APPEND;
          end
        end else begin
          if (rear_full) begin
            res.status = ST_OVERFLOW;
          end else begin
            rear_next    = rear + AW'(1);
            count_next   = count + CNT_W'(1);
            front_ctl.op = OP_APPEND;
            rear_ctl.op  = OP_SHIFT_IN;
          end
        end
      end
      MODE_POP_FRONT, MODE_POP_REAR: begin
        if (is_empty) begin
          res.status = ST_UNDERFLOW;
        end else begin
          count_next = count - CNT_W'(1);
          if (req.mode == MODE_POP_FRONT) begin
            res.data_out = front_head;
            front_ctl.op = OP_SHIFT_OUT;
            front_next   = front + AW'(1);
          end else begin
            res.data_out = rear_head;
            rear_ctl.op  = OP_SHIFT_OUT;
            rear_next    = rear - AW'(1);
          end
          // Taking the last word resets both indices.
          if (count == CNT_W'(1)) begin
            front_next = '0;
            rear_next  = '0;
          end
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase

    if (!accept) begin
      front_ctl.op = OP_HOLD;
      rear_ctl.op  = OP_HOLD;
    end
  end

  // ----------------------------------------------------------------------
  // Two cell chains: one with the front word at its head, one with the
  // rear word at its head.
  // ----------------------------------------------------------------------
  lad_chain #(.DEPTH(DEPTH)) u_front_chain (
    .clk   (clk),
    .ctl   (front_ctl),
    .count (count),
    .head  (front_head)
  );

  lad_chain #(.DEPTH(DEPTH)) u_rear_chain (
    .clk   (clk),
    .ctl   (rear_ctl),
    .count (count),
    .head  (rear_head)
  );

  // ----------------------------------------------------------------------
  // Index registers.
  // ----------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear  <= '0;
      count <= '0;
    end else if (accept) begin
      front <= front_next;
      rear  <= rear_next;
      count <= count_next;
    end
  end

  // ----------------------------------------------------------------------
  // Output register with skid register behind it.
  // ----------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!rsp_valid || take) begin
        rsp_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      rsp_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!rsp_valid || take) begin
        rsp <= res;
      end else begin
        rsp_skid <= res;
      end
    end else if (take && skid_valid) begin
      rsp <= rsp_skid;
    end
  end

  // ----------------------------------------------------------------------
  // Assertions.
  // ----------------------------------------------------------------------
  assign overflow_beat = accept && (res.status == ST_OVERFLOW);
  assign last_pop_beat = accept && (res.status == ST_OK) && req.mode[1] &&
                         (count == CNT_W'(1));

  `LAD_ASSERT_NOW(a_skid_behind_out, skid_valid, rsp_valid)
  `LAD_ASSERT_NOW(a_index_span, !is_empty, (CNT_W'(rear) - CNT_W'(front) + CNT_W'(1)) == count)
  `LAD_ASSERT_NEXT(a_overflow_keeps, overflow_beat, $stable({front, rear, count}))
  `LAD_ASSERT_NEXT(a_last_pop_empties, last_pop_beat, ({front, rear, count} == '0))

endmodule

`default_nettype wire
